// ===== rtl/core/rfp_pkg.sv =====
// rfp_pkg: shared constants, codes and types for the rank fusion pool.
// Used by rfp_ctrl, rfp_dp, rank_fusion_pool and rfp_checker. No dependencies.
package rfp_pkg;

   localparam int POOL_DEPTH  = 32;
   localparam int RANK_OFFSET = 60;
   localparam int MAX_OUT     = 32;

   localparam int IDX_W   = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
   localparam int CNT_W   = $clog2(POOL_DEPTH + 1);
   localparam int K_W     = 6;
   localparam int KEY_W   = 256;
   localparam int CHUNK_W = 16;
   localparam int SCORE_W = 24;
   localparam int COS_W   = 16;
   localparam int RANK_W  = 16;
   localparam int DIV_W   = 17;
   localparam int NUM_W   = SCORE_W + 1;
   localparam int DCNT_W  = $clog2(NUM_W);

   localparam int REQ_DATA_W = 296;
   localparam int RSP_DATA_W = 328;

   localparam logic [SCORE_W-1:0] SCORE_MAX = '1;
   localparam logic [RANK_W-1:0]  RANK_MAX  = '1;

   localparam logic [1:0] LEG_VECTOR = 2'd2;

   localparam logic CSR_TOP_K   = 1'b0;
   localparam logic CSR_MIN_COS = 1'b1;

   typedef enum logic [1:0] {
      REQ_CLEAR = 2'd0,
      REQ_HIT   = 2'd1,
      REQ_READ  = 2'd2,
      REQ_NONE  = 2'd3
   } req_kind_type;

   typedef enum logic [2:0] {
      ST_NEW    = 3'd0,
      ST_MERGED = 3'd1,
      ST_DUP    = 3'd2,
      ST_FULL   = 3'd3,
      ST_RANKED = 3'd4,
      ST_EMPTY  = 3'd5,
      ST_SUPP   = 3'd6
   } status_type;

   typedef struct packed {
      logic [KEY_W-1:0]   key;
      logic [CHUNK_W-1:0] chunk;
      logic [2:0]         legs;
      logic [SCORE_W-1:0] score;
      logic [COS_W-1:0]   cos;
      logic               known;
   } entry_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_LATCH,
      OP_CLEAR,
      OP_EMIT_BADLEG,
      OP_SCAN_START,
      OP_READ,
      OP_HIT_CHECK,
      OP_HIT_RANK,
      OP_DIV,
      OP_HIT_WRITE,
      OP_EMIT_DUP,
      OP_EMIT_FULL,
      OP_COS_CHECK,
      OP_EMIT_SUPP,
      OP_EMIT_EMPTY,
      OP_SEL_INIT
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
      logic      sel_check;
      logic      sel_emit;
   } dp_cmd_type;

   typedef struct packed {
      req_kind_type kind;
      logic         leg_bad;
      logic         idx_end;
      logic         match;
      logic         dup;
      logic         found;
      logic         full;
      logic         div_done;
      logic         suppress;
      logic         nout_zero;
      logic         sel_last;
      logic         out_free;
   } dp_stat_type;

endpackage

// ===== rtl/core/rfp_ctrl.sv =====
// rfp_ctrl: sequencer for the rank fusion pool.
// Depends on rfp_pkg; drives rfp_dp through dp_cmd_type, reads dp_stat_type.
module rfp_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  rfp_pkg::dp_stat_type stat,
   output rfp_pkg::dp_cmd_type  cmd
);

   typedef enum logic [4:0] {
      S_IDLE, S_DISPATCH, S_CLEAR, S_BADLEG,
      S_HIT_START, S_HIT_SCAN, S_HIT_CHK, S_EMIT_DUP, S_HIT_RANK,
      S_EMIT_FULL, S_DIV, S_HIT_WR,
      S_RO_START, S_COS_SCAN, S_COS_CHK, S_RO_DECIDE, S_EMIT_SUPP,
      S_EMIT_EMPTY, S_SEL_SCAN, S_SEL_CHK, S_SEL_OUT
   } state_type;

   state_type state_ff, state_in;
   logic      ready_ff;

   assign req_tready = ready_ff;

   always_comb begin
      state_in      = state_ff;
      cmd.op        = rfp_pkg::OP_NONE;
      cmd.sel_check = 1'b0;
      cmd.sel_emit  = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid && ready_ff) begin
               cmd.op   = rfp_pkg::OP_LATCH;
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            case (stat.kind)
               rfp_pkg::REQ_CLEAR: state_in = S_CLEAR;
               rfp_pkg::REQ_HIT:   state_in = stat.leg_bad ? S_BADLEG : S_HIT_START;
               rfp_pkg::REQ_READ:  state_in = S_RO_START;
               default:            state_in = S_IDLE;
            endcase
         end
         S_CLEAR: begin
            if (stat.out_free) begin
               cmd.op   = rfp_pkg::OP_CLEAR;
               state_in = S_IDLE;
            end
         end
         S_BADLEG: begin
            if (stat.out_free) begin
               cmd.op   = rfp_pkg::OP_EMIT_BADLEG;
               state_in = S_IDLE;
            end
         end
         S_HIT_START: begin
            cmd.op   = rfp_pkg::OP_SCAN_START;
            state_in = S_HIT_SCAN;
         end
         S_HIT_SCAN: begin
            if (stat.idx_end) begin
               state_in = S_HIT_RANK;
            end else begin
               cmd.op   = rfp_pkg::OP_READ;
               state_in = S_HIT_CHK;
            end
         end
         S_HIT_CHK: begin
            cmd.op = rfp_pkg::OP_HIT_CHECK;
            if (stat.match) begin
               state_in = stat.dup ? S_EMIT_DUP : S_HIT_RANK;
            end else begin
               state_in = S_HIT_SCAN;
            end
         end
         S_EMIT_DUP: begin
            if (stat.out_free) begin
               cmd.op   = rfp_pkg::OP_EMIT_DUP;
               state_in = S_IDLE;
            end
         end
         S_HIT_RANK: begin
            cmd.op   = rfp_pkg::OP_HIT_RANK;
            state_in = (!stat.found && stat.full) ? S_EMIT_FULL : S_DIV;
         end
         S_EMIT_FULL: begin
            if (stat.out_free) begin
               cmd.op   = rfp_pkg::OP_EMIT_FULL;
               state_in = S_IDLE;
            end
         end
         S_DIV: begin
            cmd.op = rfp_pkg::OP_DIV;
            if (stat.div_done) state_in = S_HIT_WR;
         end
         S_HIT_WR: begin
            if (stat.out_free) begin
               cmd.op   = rfp_pkg::OP_HIT_WRITE;
               state_in = S_IDLE;
            end
         end
         S_RO_START: begin
            cmd.op   = rfp_pkg::OP_SCAN_START;
            state_in = S_COS_SCAN;
         end
         S_COS_SCAN: begin
            if (stat.idx_end) begin
               state_in = S_RO_DECIDE;
            end else begin
               cmd.op   = rfp_pkg::OP_READ;
               state_in = S_COS_CHK;
            end
         end
         S_COS_CHK: begin
            cmd.op   = rfp_pkg::OP_COS_CHECK;
            state_in = S_COS_SCAN;
         end
         S_RO_DECIDE: begin
            if (stat.suppress) begin
               state_in = S_EMIT_SUPP;
            end else if (stat.nout_zero) begin
               state_in = S_EMIT_EMPTY;
            end else begin
               cmd.op   = rfp_pkg::OP_SEL_INIT;
               state_in = S_SEL_SCAN;
            end
         end
         S_EMIT_SUPP: begin
            if (stat.out_free) begin
               cmd.op   = rfp_pkg::OP_EMIT_SUPP;
               state_in = S_IDLE;
            end
         end
         S_EMIT_EMPTY: begin
            if (stat.out_free) begin
               cmd.op   = rfp_pkg::OP_EMIT_EMPTY;
               state_in = S_IDLE;
            end
         end
         S_SEL_SCAN: begin
            if (stat.idx_end) begin
               state_in = S_SEL_OUT;
            end else begin
               cmd.op   = rfp_pkg::OP_READ;
               state_in = S_SEL_CHK;
            end
         end
         S_SEL_CHK: begin
            cmd.sel_check = 1'b1;
            state_in      = S_SEL_SCAN;
         end
         S_SEL_OUT: begin
            if (stat.out_free) begin
               cmd.sel_emit = 1'b1;
               state_in     = stat.sel_last ? S_IDLE : S_SEL_SCAN;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ready_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         ready_ff <= (state_in == S_IDLE);
      end
   end

endmodule

// ===== rtl/core/rfp_dp.sv =====
// rfp_dp: datapath of the rank fusion pool: pool memory, rank counters,
// serial divider, scan registers and output register. Depends on rfp_pkg.
module rfp_dp (
   input  logic                             clock,
   input  logic                             reset,
   input  logic [1:0]                       req_tuser,
   input  logic [rfp_pkg::REQ_DATA_W-1:0]   req_tdata,
   input  logic                             csr_we,
   input  logic                             csr_addr,
   input  logic [15:0]                      csr_wdata,
   input  rfp_pkg::dp_cmd_type              cmd,
   output rfp_pkg::dp_stat_type             stat,
   input  logic                             rsp_tready,
   output logic                             rsp_tvalid,
   output logic [rfp_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   output logic [2:0]                       rsp_tuser,
   output logic                             rsp_tlast
);

   localparam int IW = rfp_pkg::IDX_W;
   localparam int CW = rfp_pkg::CNT_W;
   localparam int DW = rfp_pkg::DIV_W;
   localparam int NW = rfp_pkg::NUM_W;
   localparam int SW = rfp_pkg::SCORE_W;

   // latched request
   rfp_pkg::req_kind_type          kind_ff;
   logic [1:0]                     leg_ff;
   logic [rfp_pkg::KEY_W-1:0]      key_ff;
   logic [rfp_pkg::CHUNK_W-1:0]    chunk_ff;
   logic [rfp_pkg::COS_W-1:0]      sim_ff;

   // pool state and config
   rfp_pkg::entry_type             mem [rfp_pkg::POOL_DEPTH];
   logic [CW-1:0]                  count_ff;
   logic [rfp_pkg::RANK_W-1:0]     rank_ff [3];
   logic [rfp_pkg::K_W-1:0]        top_k_ff;
   logic signed [15:0]             min_cos_ff;

   // scan and work registers
   rfp_pkg::entry_type             rd_ff, work_ff, pick_ff;
   logic [CW-1:0]                  idx_ff;
   logic                           found_ff, any_ff, pick_ok_ff;
   logic signed [15:0]             best_ff;
   logic [IW-1:0]                  pick_idx_ff;
   logic [rfp_pkg::POOL_DEPTH-1:0] taken_ff;
   logic [rfp_pkg::K_W-1:0]        k_ff;

   // divider
   logic [DW-1:0]                  div_d_ff, div_rem_ff;
   logic [NW-1:0]                  div_num_ff, div_q_ff;
   logic [rfp_pkg::DCNT_W-1:0]     div_cnt_ff;

   // output register
   logic                           rsp_valid_ff;
   logic [rfp_pkg::RSP_DATA_W-1:0] rsp_data_ff;
   logic [2:0]                     rsp_user_ff;
   logic                           rsp_last_ff;

   logic [rfp_pkg::RANK_W-1:0]     rank_cur, rank_new;
   logic [DW-1:0]                  d_new;
   logic [DW:0]                    rem_sh, rem_sub;
   logic                           rem_ge;
   logic [SW:0]                    score_sum;
   logic [2:0]                     leg_bit;
   rfp_pkg::entry_type             upd, new_ent, in_ent;
   logic [6:0]                     nout_w;
   logic [rfp_pkg::K_W-1:0]        nout;
   logic                           better, out_free;
   logic                           ld_en, ld_last;
   rfp_pkg::status_type            ld_status;
   rfp_pkg::entry_type             ld_ent;
   logic [rfp_pkg::K_W-1:0]        ld_withheld;

   always_comb begin
      case (leg_ff)
         2'd0:    rank_cur = rank_ff[0];
         2'd1:    rank_cur = rank_ff[1];
         default: rank_cur = rank_ff[2];
      endcase
   end

   assign rank_new = (rank_cur == rfp_pkg::RANK_MAX) ? rank_cur : rank_cur + 1'b1;
   assign d_new    = DW'(rfp_pkg::RANK_OFFSET) + DW'(rank_new);
   assign leg_bit  = 3'b001 << leg_ff;

   // restoring divide step, one quotient bit per cycle
   assign rem_sh   = {div_rem_ff, div_num_ff[NW-1]};
   assign rem_ge   = rem_sh >= {1'b0, div_d_ff};
   assign rem_sub  = rem_sh - {1'b0, div_d_ff};

   assign score_sum = {1'b0, work_ff.score} + {1'b0, div_q_ff[SW-1:0]};

   always_comb begin
      upd = work_ff;
      upd.legs  = work_ff.legs | leg_bit;
      upd.score = score_sum[SW] ? rfp_pkg::SCORE_MAX : score_sum[SW-1:0];
      if (leg_ff == rfp_pkg::LEG_VECTOR) begin
         upd.cos   = sim_ff;
         upd.known = 1'b1;
      end
   end

   always_comb begin
      in_ent       = '0;
      in_ent.key   = key_ff;
      in_ent.chunk = chunk_ff;
      new_ent      = in_ent;
   end

   always_comb begin
      nout_w = 7'(count_ff);
      if (7'(top_k_ff) < nout_w) nout_w = 7'(top_k_ff);
      if (7'(rfp_pkg::MAX_OUT) < nout_w) nout_w = 7'(rfp_pkg::MAX_OUT);
   end
   assign nout = nout_w[rfp_pkg::K_W-1:0];

   assign better = !taken_ff[idx_ff[IW-1:0]] && (!pick_ok_ff || rd_ff.score > pick_ff.score);
   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      stat.kind      = kind_ff;
      stat.leg_bad   = (leg_ff == 2'd3);
      stat.idx_end   = (idx_ff == count_ff);
      stat.match     = (rd_ff.key == key_ff) && (rd_ff.chunk == chunk_ff);
      stat.dup       = |(rd_ff.legs & leg_bit);
      stat.found     = found_ff;
      stat.full      = (count_ff == CW'(rfp_pkg::POOL_DEPTH));
      stat.div_done  = (div_cnt_ff == rfp_pkg::DCNT_W'(NW - 1));
      stat.suppress  = any_ff && (min_cos_ff > 16'sd0) && (best_ff < min_cos_ff);
      stat.nout_zero = (nout == '0);
      stat.sel_last  = ((k_ff + 1'b1) == nout);
      stat.out_free  = out_free;
   end

   // what goes into the output register this cycle
   always_comb begin
      ld_en       = 1'b1;
      ld_status   = rfp_pkg::ST_EMPTY;
      ld_ent      = '0;
      ld_withheld = '0;
      ld_last     = 1'b1;
      if (cmd.sel_emit) begin
         ld_status = rfp_pkg::ST_RANKED;
         ld_ent    = pick_ff;
         ld_last   = stat.sel_last;
      end else begin
         case (cmd.op)
            rfp_pkg::OP_CLEAR:       ld_status = rfp_pkg::ST_EMPTY;
            rfp_pkg::OP_EMIT_EMPTY:  ld_status = rfp_pkg::ST_EMPTY;
            rfp_pkg::OP_EMIT_BADLEG: begin
               ld_status = rfp_pkg::ST_DUP;
               ld_ent    = in_ent;
            end
            rfp_pkg::OP_EMIT_FULL: begin
               ld_status = rfp_pkg::ST_FULL;
               ld_ent    = in_ent;
            end
            rfp_pkg::OP_EMIT_DUP: begin
               ld_status = rfp_pkg::ST_DUP;
               ld_ent    = rd_ff;
            end
            rfp_pkg::OP_HIT_WRITE: begin
               ld_status = found_ff ? rfp_pkg::ST_MERGED : rfp_pkg::ST_NEW;
               ld_ent    = upd;
            end
            rfp_pkg::OP_EMIT_SUPP: begin
               ld_status   = rfp_pkg::ST_SUPP;
               ld_withheld = nout;
            end
            default: ld_en = 1'b0;
         endcase
      end
   end

   // pool memory: one write or one registered read per cycle
   always_ff @(posedge clock) begin
      if (cmd.op == rfp_pkg::OP_HIT_WRITE) mem[idx_ff[IW-1:0]] <= upd;
      if (cmd.op == rfp_pkg::OP_READ) rd_ff <= mem[idx_ff[IW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rank_ff[0]   <= '0;
         rank_ff[1]   <= '0;
         rank_ff[2]   <= '0;
         top_k_ff     <= rfp_pkg::K_W'(5);
         min_cos_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_addr)
               rfp_pkg::CSR_TOP_K:   top_k_ff   <= csr_wdata[rfp_pkg::K_W-1:0];
               rfp_pkg::CSR_MIN_COS: min_cos_ff <= csr_wdata;
               default: ;
            endcase
         end

         if (ld_en) rsp_valid_ff <= 1'b1;
         else if (rsp_tready) rsp_valid_ff <= 1'b0;

         if (cmd.op == rfp_pkg::OP_CLEAR) begin
            count_ff   <= '0;
            rank_ff[0] <= '0;
            rank_ff[1] <= '0;
            rank_ff[2] <= '0;
         end
         if (cmd.op == rfp_pkg::OP_HIT_RANK) begin
            for (int i = 0; i < 3; i++) begin
               if (leg_ff == 2'(i)) rank_ff[i] <= rank_new;
            end
            if (!found_ff && !stat.full) count_ff <= count_ff + 1'b1;
         end
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (ld_en) begin
         rsp_user_ff <= ld_status;
         rsp_last_ff <= ld_last;
         rsp_data_ff <= {6'd0, ld_withheld, ld_ent.known, ld_ent.cos, ld_ent.legs,
                         ld_ent.score, ld_ent.chunk, ld_ent.key};
      end
      if (cmd.sel_check) begin
         if (better) begin
            pick_ff     <= rd_ff;
            pick_idx_ff <= idx_ff[IW-1:0];
            pick_ok_ff  <= 1'b1;
         end
         idx_ff <= idx_ff + 1'b1;
      end
      if (cmd.sel_emit) begin
         taken_ff[pick_idx_ff] <= 1'b1;
         k_ff       <= k_ff + 1'b1;
         idx_ff     <= '0;
         pick_ok_ff <= 1'b0;
      end
      case (cmd.op)
         rfp_pkg::OP_LATCH: begin
            kind_ff  <= rfp_pkg::req_kind_type'(req_tuser);
            leg_ff   <= req_tdata[1:0];
            key_ff   <= req_tdata[257:2];
            chunk_ff <= req_tdata[273:258];
            sim_ff   <= req_tdata[289:274];
         end
         rfp_pkg::OP_SCAN_START: begin
            idx_ff   <= '0;
            found_ff <= 1'b0;
            any_ff   <= 1'b0;
            best_ff  <= '0;
         end
         rfp_pkg::OP_HIT_CHECK: begin
            if (stat.match) found_ff <= 1'b1;
            else idx_ff <= idx_ff + 1'b1;
         end
         rfp_pkg::OP_HIT_RANK: begin
            work_ff    <= found_ff ? rd_ff : new_ent;
            div_d_ff   <= d_new;
            div_rem_ff <= '0;
            div_num_ff <= {1'b1, {(NW - 1){1'b0}}} + NW'(d_new[DW-1:1]);
            div_q_ff   <= '0;
            div_cnt_ff <= '0;
         end
         rfp_pkg::OP_DIV: begin
            div_rem_ff <= rem_ge ? rem_sub[DW-1:0] : rem_sh[DW-1:0];
            div_q_ff   <= {div_q_ff[NW-2:0], rem_ge};
            div_num_ff <= {div_num_ff[NW-2:0], 1'b0};
            div_cnt_ff <= div_cnt_ff + 1'b1;
         end
         rfp_pkg::OP_COS_CHECK: begin
            if (rd_ff.known) begin
               if (!any_ff || $signed(rd_ff.cos) > best_ff) best_ff <= $signed(rd_ff.cos);
               any_ff <= 1'b1;
            end
            idx_ff <= idx_ff + 1'b1;
         end
         rfp_pkg::OP_SEL_INIT: begin
            taken_ff   <= '0;
            k_ff       <= '0;
            idx_ff     <= '0;
            pick_ok_ff <= 1'b0;
         end
         default: ;
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

// ===== rtl/core/rank_fusion_pool.sv =====
// rank_fusion_pool: top level of the reciprocal rank fusion candidate pool.
// Depends on rfp_pkg, rfp_ctrl and rfp_dp.

// Fuses ranked hits from three retrieval legs (keyword, literal, vector) into a
// pool of up to 32 candidates keyed by a 256-bit hash plus chunk index. Each
// scored hit adds round(2^24/(60+rank)) to the entry's Q0.24 score; readout
// streams entries by descending score (ties to the older entry) or a single
// suppressed transaction when the best vector cosine is under min_cosine > 0.
// One request transaction is worked at a time; hits and readouts walk the pool
// one entry at a time through a single registered memory read port. A hit
// searches the pool and, unless it is a duplicate or finds the pool full,
// then runs a 25-step bit-serial divider; a readout makes a cosine scan and
// then one full scan of the pool per emitted entry. Results stall on
// rsp_tready; the result register lets the next request be taken while the
// final result transaction is still waiting on rsp_tready.
module rank_fusion_pool (
   input  logic                           clock,
   input  logic                           reset,
   // request channel
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // tdata: leg[1:0], key_word0..3[257:2], chunk_index[273:258],
   //        similarity[289:274], zero pad to 296
   input  logic [rfp_pkg::REQ_DATA_W-1:0] req_tdata,
   // tuser: req_type[1:0]
   input  logic [1:0]                     req_tuser,
   // result channel
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // tdata: out_key0..3[255:0], out_chunk[271:256], fused_score[295:272],
   //        leg_mask[298:296], out_cosine[314:299], cosine_known[315],
   //        withheld[321:316], zero pad to 328
   output logic [rfp_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // tuser: status[2:0]
   output logic [2:0]                     rsp_tuser,
   output logic                           rsp_tlast,
   // config: index 0 top_k, index 1 min_cosine
   input  logic                           csr_we,
   input  logic                           csr_addr,
   input  logic [15:0]                    csr_wdata
);

   rfp_pkg::dp_cmd_type  cmd;
   rfp_pkg::dp_stat_type stat;

   rfp_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   rfp_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .cmd        (cmd),
      .stat       (stat),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// ===== rtl/core/rfp_checker.sv =====
// rfp_checker: port-level assertions for rank_fusion_pool, bound to the top.
// Depends on rfp_pkg.
module rfp_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_tvalid,
   input logic                           req_tready,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [rfp_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic [2:0]                     rsp_tuser,
   input logic                           rsp_tlast
);

   // result held until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result dropped before accept");

   // one request transaction at a time
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while busy");

   // withheld is only nonzero on a suppressed result
   a_withheld: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser != rfp_pkg::ST_SUPP) |-> (rsp_tdata[321:316] == 6'd0))
      else $error("withheld set on non-suppressed result");

   // every status other than ranked is a single, final transaction
   a_single_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser != rfp_pkg::ST_RANKED) |-> rsp_tlast)
      else $error("single result without tlast");

endmodule

bind rank_fusion_pool rfp_checker u_rfp_checker (.*);

// ===== bench/tb.sv =====
// tb: self-checking bench for rank_fusion_pool; drives hit, clear, readout and
// no-op requests and register writes, predicts every result and checks them in order.
// Depends on rfp_pkg and the rank_fusion_pool RTL.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   // one expected (or observed) result transaction
   typedef struct {
      rfp_pkg::status_type status;
      logic [255:0] key;
      logic [15:0]  chunk;
      logic [23:0]  score;
      logic [2:0]   legs;
      logic [15:0]  cos;
      logic         known;
      logic [5:0]   withheld;
      logic         last;
   } fusion_rsp_type;

   // predictor of the pool plus a queue of results still owed
   class fusion_board;
      logic [255:0] pkey[rfp_pkg::POOL_DEPTH];
      logic [15:0]  pchunk[rfp_pkg::POOL_DEPTH];
      logic [2:0]   plegs[rfp_pkg::POOL_DEPTH];
      logic [23:0]  pscore[rfp_pkg::POOL_DEPTH];
      logic [15:0]  pcos[rfp_pkg::POOL_DEPTH];
      logic         pknown[rfp_pkg::POOL_DEPTH];
      int unsigned  fill;
      int unsigned  rank[3];
      int unsigned  top_k;
      logic signed [15:0] floor_cos;
      fusion_rsp_type owed[$];
      int           errors;

      function new();
         fill = 0; rank = '{0, 0, 0};
         top_k = 5; floor_cos = 0; errors = 0;
      endfunction

      function void set_reg(logic idx, logic [15:0] v);
         if (idx == rfp_pkg::CSR_TOP_K) top_k = {26'd0, v[5:0]};
         else floor_cos = v;
      endfunction

      function fusion_rsp_type blank(rfp_pkg::status_type s);
         fusion_rsp_type r;
         r.status = s; r.key = '0; r.chunk = '0; r.score = '0; r.legs = '0;
         r.cos = '0; r.known = 1'b0; r.withheld = '0; r.last = 1'b1;
         return r;
      endfunction

      function fusion_rsp_type of_entry(rfp_pkg::status_type s, int i, logic lst);
         fusion_rsp_type r;
         r = blank(s);
         r.key = pkey[i]; r.chunk = pchunk[i]; r.score = pscore[i];
         r.legs = plegs[i]; r.known = pknown[i];
         r.cos = pknown[i] ? pcos[i] : 16'h0; r.last = lst;
         return r;
      endfunction

      // note an accepted request and queue what it must produce
      function void note_request(rfp_pkg::req_kind_type kind, logic [1:0] leg,
                                 logic [255:0] key, logic [15:0] chunk,
                                 logic [15:0] sim);
         int found, nout, pick;
         int unsigned d, add, s;
         bit any;
         logic signed [15:0] best;
         logic [rfp_pkg::POOL_DEPTH-1:0] taken;
         fusion_rsp_type r;
         case (kind)
            rfp_pkg::REQ_CLEAR: begin
               fill = 0; rank = '{0, 0, 0};
               owed.push_back(blank(rfp_pkg::ST_EMPTY));
            end
            rfp_pkg::REQ_HIT: begin
               if (leg > 2'd2) begin
                  r = blank(rfp_pkg::ST_DUP); r.key = key; r.chunk = chunk;
                  owed.push_back(r);
                  return;
               end
               found = -1;
               for (int i = 0; i < int'(fill); i++)
                  if (found < 0 && pkey[i] == key && pchunk[i] == chunk) found = i;
               if (found >= 0 && plegs[found][leg]) begin
                  owed.push_back(of_entry(rfp_pkg::ST_DUP, found, 1'b1));
                  return;
               end
               if (rank[leg] < 65535) rank[leg]++;
               if (found < 0) begin
                  if (fill >= rfp_pkg::POOL_DEPTH) begin
                     r = blank(rfp_pkg::ST_FULL); r.key = key; r.chunk = chunk;
                     owed.push_back(r);
                     return;
                  end
                  found = int'(fill);
                  fill++;
                  pkey[found] = key; pchunk[found] = chunk; plegs[found] = '0;
                  pscore[found] = '0; pcos[found] = '0; pknown[found] = 1'b0;
                  r.status = rfp_pkg::ST_NEW;
               end else
                  r.status = rfp_pkg::ST_MERGED;
               plegs[found][leg] = 1'b1;
               if (leg == rfp_pkg::LEG_VECTOR) begin
                  pcos[found] = sim; pknown[found] = 1'b1;
               end
               d = 32'(rfp_pkg::RANK_OFFSET) + rank[leg];
               add = ((32'd1 << 24) + d / 32'd2) / d;
               s = {8'd0, pscore[found]} + add;
               pscore[found] = (s > 32'hFFFFFF) ? 24'hFFFFFF : s[23:0];
               owed.push_back(of_entry(r.status, found, 1'b1));
            end
            rfp_pkg::REQ_READ: begin
               nout = int'(fill);
               if (nout > int'(top_k)) nout = int'(top_k);
               any = 0; best = 0;
               for (int i = 0; i < int'(fill); i++)
                  if (pknown[i]) begin
                     if (!any || $signed(pcos[i]) > best) best = $signed(pcos[i]);
                     any = 1;
                  end
               if (any && floor_cos > 0 && best < floor_cos) begin
                  r = blank(rfp_pkg::ST_SUPP); r.withheld = 6'(nout);
                  owed.push_back(r);
               end else if (nout == 0)
                  owed.push_back(blank(rfp_pkg::ST_EMPTY));
               else begin
                  taken = '0;
                  for (int k = 0; k < nout; k++) begin
                     pick = -1;
                     for (int i = 0; i < int'(fill); i++)
                        if (!taken[i] && (pick < 0 || pscore[i] > pscore[pick]))
                           pick = i;
                     taken[pick] = 1'b1;
                     owed.push_back(of_entry(rfp_pkg::ST_RANKED, pick, k + 1 == nout));
                  end
               end
            end
            default: ;
         endcase
      endfunction

      // compare one observed result with the oldest owed one
      function void check_result(fusion_rsp_type got);
         fusion_rsp_type e;
         if (owed.size() == 0) begin
            $error("unexpected result status=%0d", got.status);
            errors++;
            return;
         end
         e = owed.pop_front();
         if (got.status !== e.status) begin
            $error("status exp %0d got %0d", e.status, got.status); errors++;
         end
         if (got.key !== e.key) begin
            $error("out_key exp %h got %h", e.key, got.key); errors++;
         end
         if (got.chunk !== e.chunk) begin
            $error("out_chunk exp %h got %h", e.chunk, got.chunk); errors++;
         end
         if (got.score !== e.score) begin
            $error("fused_score exp %h got %h", e.score, got.score); errors++;
         end
         if (got.legs !== e.legs) begin
            $error("leg_mask exp %h got %h", e.legs, got.legs); errors++;
         end
         if (got.cos !== e.cos) begin
            $error("out_cosine exp %h got %h", e.cos, got.cos); errors++;
         end
         if (got.known !== e.known) begin
            $error("cosine_known exp %h got %h", e.known, got.known); errors++;
         end
         if (got.withheld !== e.withheld) begin
            $error("withheld exp %0d got %0d", e.withheld, got.withheld); errors++;
         end
         if (got.last !== e.last) begin
            $error("last exp %0d got %0d", e.last, got.last); errors++;
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic req_tvalid = 0;
   logic req_tready;
   logic [rfp_pkg::REQ_DATA_W-1:0] req_tdata = '0;
   logic [1:0] req_tuser = '0;
   logic rsp_tvalid;
   logic rsp_tready = 0;
   logic [rfp_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic [2:0] rsp_tuser;
   logic rsp_tlast;
   logic csr_we = 0;
   logic csr_addr = 0;
   logic [15:0] csr_wdata = '0;

   fusion_board board = new();
   logic [255:0] key_pool[8];   // small set of hashes so keys repeat and merge
   bit stim_done = 0;

   rank_fusion_pool dut (.*);

   always begin
      #6 clock = 1;
      #6 clock = 0;
   end

   // mostly short gaps, now and then a long one, sometimes none
   function automatic int gap_len();
      int p;
      p = $urandom_range(0, 99);
      if (p < 40) return 0;
      if (p < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   // result side: random stall, sample at rising edge
   always @(posedge clock) begin
      fusion_rsp_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.status   = rfp_pkg::status_type'(rsp_tuser);
         got.key      = rsp_tdata[255:0];
         got.chunk    = rsp_tdata[271:256];
         got.score    = rsp_tdata[295:272];
         got.legs     = rsp_tdata[298:296];
         got.cos      = rsp_tdata[314:299];
         got.known    = rsp_tdata[315];
         got.withheld = rsp_tdata[321:316];
         got.last     = rsp_tlast;
         board.check_result(got);
      end
   end

   initial begin
      @(negedge clock);
      forever begin
         rsp_tready <= 1'b1;
         @(negedge clock);
         if ($urandom_range(0, 3) == 0) begin
            rsp_tready <= 1'b0;
            repeat (gap_len() + 1) @(negedge clock);
         end
      end
   end

   // one request transaction; drive at falling edge, accept at rising edge.
   // At least one falling edge passes after tvalid was dropped.
   task automatic send_request(rfp_pkg::req_kind_type kind, logic [1:0] leg,
                               logic [255:0] key, logic [15:0] chunk,
                               logic [15:0] sim);
      repeat (gap_len() + 1) @(negedge clock);
      req_tuser  <= kind;
      req_tdata  <= {6'b0, sim, chunk, key, leg};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      board.note_request(kind, leg, key, chunk, sim);
      @(negedge clock);
      req_tvalid <= 1'b0;
   endtask

   // registers change only with nothing pending and the block quiet
   task automatic write_reg(logic idx, logic [15:0] v);
      while (board.owed.size() != 0) @(negedge clock);
      repeat (100) @(negedge clock);
      csr_we <= 1'b1; csr_addr <= idx; csr_wdata <= v;
      @(negedge clock);
      csr_we <= 1'b0;
      board.set_reg(idx, v);
   endtask

   function automatic logic [255:0] rand_key();
      return {$urandom, $urandom, $urandom, $urandom,
              $urandom, $urandom, $urandom, $urandom};
   endfunction

   task automatic random_hit(int p_new);
      logic [255:0] k;
      logic [15:0] c;
      if ($urandom_range(0, 99) < p_new) begin
         k = rand_key(); c = 16'($urandom);
      end else begin
         k = key_pool[$urandom_range(0, 7)]; c = 16'($urandom_range(0, 1));
      end
      send_request(rfp_pkg::REQ_HIT,
                   ($urandom_range(0, 49) == 0) ? 2'd3 : 2'($urandom_range(0, 2)),
                   k, c, 16'($urandom));
   endtask

   initial begin
      int cos_sel;
      for (int i = 0; i < 8; i++) key_pool[i] = rand_key();
      key_pool[0] = '0;
      key_pool[1] = '1;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // directed: empty readout, extremes, all legs, dup, bad leg, clear
      send_request(rfp_pkg::REQ_READ, 2'd0, '0, 16'd0, 16'd0);
      send_request(rfp_pkg::REQ_HIT, 2'd0, key_pool[0], 16'h0000, 16'h8000);
      send_request(rfp_pkg::REQ_HIT, 2'd1, key_pool[0], 16'h0000, 16'd0);
      send_request(rfp_pkg::REQ_HIT, 2'd2, key_pool[0], 16'h0000, 16'h7FFF);
      send_request(rfp_pkg::REQ_HIT, 2'd2, key_pool[0], 16'h0000, 16'h1234);
      send_request(rfp_pkg::REQ_HIT, 2'd2, key_pool[1], 16'hFFFF, 16'h8000);
      send_request(rfp_pkg::REQ_HIT, 2'd3, key_pool[1], 16'hFFFF, 16'h5555);
      send_request(rfp_pkg::REQ_HIT, 2'd0, key_pool[1], 16'hFFFF, 16'd0);
      send_request(rfp_pkg::REQ_READ, 2'd0, '0, 16'd0, 16'd0);
      send_request(rfp_pkg::REQ_NONE, 2'd0, key_pool[2], 16'h1, 16'd0);
      send_request(rfp_pkg::REQ_READ, 2'd0, '0, 16'd0, 16'd0);
      write_reg(rfp_pkg::CSR_MIN_COS, 16'h7FFF);      // floor equal to the best cosine: no suppression
      send_request(rfp_pkg::REQ_READ, 2'd0, '0, 16'd0, 16'd0);
      write_reg(rfp_pkg::CSR_MIN_COS, 16'h8000);      // negative floor: disabled
      send_request(rfp_pkg::REQ_READ, 2'd0, '0, 16'd0, 16'd0);
      // fill the pool past its depth to reach pool-full
      for (int i = 0; i < 34; i++)
         send_request(rfp_pkg::REQ_HIT, 2'd1, rand_key(), 16'(i), 16'd0);
      write_reg(rfp_pkg::CSR_TOP_K, 16'd32);
      send_request(rfp_pkg::REQ_READ, 2'd0, '0, 16'd0, 16'd0);
      write_reg(rfp_pkg::CSR_TOP_K, 16'd0);
      send_request(rfp_pkg::REQ_READ, 2'd0, '0, 16'd0, 16'd0);
      send_request(rfp_pkg::REQ_CLEAR, 2'd0, '0, 16'd0, 16'd0);
      send_request(rfp_pkg::REQ_READ, 2'd0, '0, 16'd0, 16'd0);

      // random phases, each under its own register setting
      for (int ph = 0; ph < 10; ph++) begin
         write_reg(rfp_pkg::CSR_TOP_K, (ph == 0) ? 16'd1 : (ph == 1) ? 16'd63
                              : 16'($urandom_range(1, 32)));
         cos_sel = $urandom_range(0, 3);
         write_reg(rfp_pkg::CSR_MIN_COS, (cos_sel == 0) ? 16'h0000 :
                   (cos_sel == 1) ? 16'h0001 : (cos_sel == 2) ? 16'h7FFF
                   : 16'($urandom));
         for (int i = 0; i < 33; i++) begin
            case ($urandom_range(0, 19))
               0:        send_request(rfp_pkg::REQ_CLEAR, 2'($urandom), rand_key(),
                                      16'($urandom), 16'($urandom));
               1, 2:     send_request(rfp_pkg::REQ_READ, 2'($urandom), rand_key(),
                                      16'($urandom), 16'($urandom));
               3:        send_request(rfp_pkg::REQ_NONE, 2'($urandom), rand_key(),
                                      16'($urandom), 16'($urandom));
               default:  random_hit(ph == 9 ? 70 : 25);
            endcase
         end
         send_request(rfp_pkg::REQ_READ, 2'd0, '0, 16'd0, 16'd0);
      end

      while (board.owed.size() != 0) @(negedge clock);
      repeat (200) @(negedge clock);
      if (board.errors == 0) $display("*** PASSED ***");
      else $display("*** FAILED ***");
      $finish;
   end

   // watchdog
   initial begin
      #200ms;
      $display("*** FAILED ***");
      $finish;
   end
endmodule
